// File: hw/rtl/q2e_pkg.sv
`timescale 1ns / 1ps
package q2e_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ATAN_TAB_LEN = 24;
	localparam int CORDIC_STAGES = (CORDIC_ITERATIONS < ATAN_TAB_LEN) ?
		CORDIC_ITERATIONS : ATAN_TAB_LEN;

	localparam int TERM_W = 35;   // products and terms, 28 fraction bits
	localparam int R21_W = 30;    // r21 after saturation to [-1,1]
	localparam int RAD_W = 57;    // 1 - r21^2, 56 fraction bits
	localparam int ROOT_W = 29;   // floor sqrt, 28 fraction bits
	localparam int CXY_W = 38;    // CORDIC vector width
	localparam int ANG_W = 34;    // CORDIC angle, 30 fraction bits

	localparam int TERMS_LAT = 5;
	localparam int CORDIC_LAT = CORDIC_STAGES + 1;

	localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd1 <<< 28);
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'sd1686629713);

	typedef enum logic [3:0] {
		SEQ_ZYX = 4'd0,
		SEQ_ZYZ = 4'd1,
		SEQ_ZXY = 4'd2,
		SEQ_ZXZ = 4'd3,
		SEQ_YXZ = 4'd4,
		SEQ_YXY = 4'd5,
		SEQ_YZX = 4'd6,
		SEQ_YZY = 4'd7,
		SEQ_XYZ = 4'd8,
		SEQ_XYX = 4'd9,
		SEQ_XZY = 4'd10,
		SEQ_XZX = 4'd11
	} seq_t;

	localparam logic [3:0] SEQ_RESET = SEQ_ZXY;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] angle_first;
		logic signed [15:0] angle_second;
		logic signed [15:0] angle_third;
		logic               argument_clamped;
	} euler_t;

	typedef struct packed {
		logic clamped;
		logic bad;     // sequence code without meaning
	} flag_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] r11;
		logic signed [TERM_W-1:0] r12;
		logic signed [R21_W-1:0]  r21;
		logic signed [TERM_W-1:0] r31;
		logic signed [TERM_W-1:0] r32;
		logic                     three;
		flag_t                    flags;
	} side_t;

	function automatic logic signed [ANG_W-1:0] atan_angle(input logic [4:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:  v = 32'sd843314857;
			5'd1:  v = 32'sd497837829;
			5'd2:  v = 32'sd263043837;
			5'd3:  v = 32'sd133525159;
			5'd4:  v = 32'sd67021687;
			5'd5:  v = 32'sd33543516;
			5'd6:  v = 32'sd16775851;
			5'd7:  v = 32'sd8388437;
			5'd8:  v = 32'sd4194283;
			5'd9:  v = 32'sd2097149;
			5'd10: v = 32'sd1048576;
			5'd11: v = 32'sd524288;
			5'd12: v = 32'sd262144;
			5'd13: v = 32'sd131072;
			5'd14: v = 32'sd65536;
			5'd15: v = 32'sd32768;
			5'd16: v = 32'sd16384;
			5'd17: v = 32'sd8192;
			5'd18: v = 32'sd4096;
			5'd19: v = 32'sd2048;
			5'd20: v = 32'sd1024;
			5'd21: v = 32'sd512;
			5'd22: v = 32'sd256;
			5'd23: v = 32'sd128;
			default: v = 32'sd0;
		endcase
		return ANG_W'(v);
	endfunction

endpackage

// File: hw/rtl/q2e_terms.sv
`timescale 1ns / 1ps
module q2e_terms import q2e_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  quat_t             quat,
	input  logic [3:0]        seq,
	output logic              out_valid,
	output side_t             side,
	output logic [RAD_W-1:0]  rad
);

	logic [TERMS_LAT-1:0] v_s;

	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [31:0] xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic [3:0]         seq_s1;

	logic signed [TERM_W-1:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2;
	logic signed [TERM_W-1:0] sx_s2, sy_s2, sz_s2;
	logic [3:0]               seq_s2;

	side_t                    sel;
	logic signed [TERM_W-1:0] r21_raw;
	side_t                    side_s3, side_s4, side_s5;
	logic signed [2*R21_W-1:0] sq_s4;
	logic [RAD_W-1:0]         rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[TERMS_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s1  <= quat.quat_w * quat.quat_w;
			xx_s1  <= quat.quat_x * quat.quat_x;
			yy_s1  <= quat.quat_y * quat.quat_y;
			zz_s1  <= quat.quat_z * quat.quat_z;
			xy_s1  <= quat.quat_x * quat.quat_y;
			wz_s1  <= quat.quat_w * quat.quat_z;
			xz_s1  <= quat.quat_x * quat.quat_z;
			wy_s1  <= quat.quat_w * quat.quat_y;
			yz_s1  <= quat.quat_y * quat.quat_z;
			wx_s1  <= quat.quat_w * quat.quat_x;
			seq_s1 <= seq;

			a_s2  <= (TERM_W'(xy_s1) + TERM_W'(wz_s1)) <<< 1;
			b_s2  <= (TERM_W'(xy_s1) - TERM_W'(wz_s1)) <<< 1;
			c_s2  <= (TERM_W'(xz_s1) + TERM_W'(wy_s1)) <<< 1;
			d_s2  <= (TERM_W'(xz_s1) - TERM_W'(wy_s1)) <<< 1;
			e_s2  <= (TERM_W'(yz_s1) + TERM_W'(wx_s1)) <<< 1;
			f_s2  <= (TERM_W'(yz_s1) - TERM_W'(wx_s1)) <<< 1;
			sx_s2 <= TERM_W'(ww_s1) + TERM_W'(xx_s1) - TERM_W'(yy_s1) - TERM_W'(zz_s1);
			sy_s2 <= TERM_W'(ww_s1) - TERM_W'(xx_s1) + TERM_W'(yy_s1) - TERM_W'(zz_s1);
			sz_s2 <= TERM_W'(ww_s1) - TERM_W'(xx_s1) - TERM_W'(yy_s1) + TERM_W'(zz_s1);
			seq_s2 <= seq_s1;

			side_s3 <= sel;

			side_s4 <= side_s3;
			sq_s4   <= side_s3.r21 * side_s3.r21;

			side_s5 <= side_s4;
			rad_s5  <= RAD_W'(65'd1 << 56) - sq_s4[RAD_W-1:0];
		end
	end

	always_comb begin
		sel = '0;
		r21_raw = '0;
		sel.three = 1'b1;
		case (seq_s2)
			SEQ_ZYX: begin sel.r11 = a_s2;  sel.r12 = sx_s2; r21_raw = -d_s2;
				sel.r31 = e_s2;  sel.r32 = sz_s2; end
			SEQ_ZYZ: begin sel.r11 = f_s2;  sel.r12 = c_s2;  r21_raw = sz_s2;
				sel.r31 = e_s2;  sel.r32 = -d_s2; sel.three = 1'b0; end
			SEQ_ZXY: begin sel.r11 = -b_s2; sel.r12 = sy_s2; r21_raw = e_s2;
				sel.r31 = -d_s2; sel.r32 = sz_s2; end
			SEQ_ZXZ: begin sel.r11 = c_s2;  sel.r12 = -f_s2; r21_raw = sz_s2;
				sel.r31 = d_s2;  sel.r32 = e_s2;  sel.three = 1'b0; end
			SEQ_YXZ: begin sel.r11 = c_s2;  sel.r12 = sz_s2; r21_raw = -f_s2;
				sel.r31 = a_s2;  sel.r32 = sy_s2; end
			SEQ_YXY: begin sel.r11 = b_s2;  sel.r12 = e_s2;  r21_raw = sy_s2;
				sel.r31 = a_s2;  sel.r32 = -f_s2; sel.three = 1'b0; end
			SEQ_YZX: begin sel.r11 = -d_s2; sel.r12 = sx_s2; r21_raw = a_s2;
				sel.r31 = -f_s2; sel.r32 = sy_s2; end
			SEQ_YZY: begin sel.r11 = e_s2;  sel.r12 = -b_s2; r21_raw = sy_s2;
				sel.r31 = f_s2;  sel.r32 = a_s2;  sel.three = 1'b0; end
			SEQ_XYZ: begin sel.r11 = -f_s2; sel.r12 = sz_s2; r21_raw = c_s2;
				sel.r31 = -b_s2; sel.r32 = sx_s2; end
			SEQ_XYX: begin sel.r11 = a_s2;  sel.r12 = -d_s2; r21_raw = sx_s2;
				sel.r31 = b_s2;  sel.r32 = c_s2;  sel.three = 1'b0; end
			SEQ_XZY: begin sel.r11 = e_s2;  sel.r12 = sy_s2; r21_raw = -b_s2;
				sel.r31 = c_s2;  sel.r32 = sx_s2; end
			SEQ_XZX: begin sel.r11 = d_s2;  sel.r12 = a_s2;  r21_raw = sx_s2;
				sel.r31 = c_s2;  sel.r32 = -b_s2; sel.three = 1'b0; end
			default: sel.flags.bad = 1'b1;
		endcase
		// saturate the asin/acos argument to the unit range
		if (r21_raw > ONE_Q28) begin
			sel.r21 = R21_W'(ONE_Q28);
			sel.flags.clamped = 1'b1;
		end else if (r21_raw < -ONE_Q28) begin
			sel.r21 = R21_W'(-ONE_Q28);
			sel.flags.clamped = 1'b1;
		end else begin
			sel.r21 = R21_W'(r21_raw);
		end
	end

	assign out_valid = v_s[TERMS_LAT-1];
	assign side = side_s5;
	assign rad = rad_s5;

	a_clamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[3] |-> (side_s4.r21 <= R21_W'(ONE_Q28)) && (side_s4.r21 >= R21_W'(-ONE_Q28)))
		else $error("r21 outside unit range after saturation");
	a_bad_noclamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(side.flags.bad && side.flags.clamped))
		else $error("undefined sequence flagged as clamped");
	a_rad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rad <= RAD_W'(65'd1 << 56))
		else $error("radicand above one");

endmodule

// File: hw/rtl/q2e_isqrt.sv
`timescale 1ns / 1ps
module q2e_isqrt import q2e_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic [RAD_W-1:0]   rad,
	input  side_t              in_side,
	output logic               out_valid,
	output logic [ROOT_W-1:0]  root,
	output side_t              out_side
);

	localparam int REM_W = RAD_W + 1;

	// one result bit per stage, MSB first; rem holds rad - root^2
	logic              v_s    [0:ROOT_W];
	logic [REM_W-1:0]  rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] root_s [0:ROOT_W];
	side_t             side_s [0:ROOT_W];

	assign v_s[0] = in_valid;
	assign rem_s[0] = REM_W'(rad);
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
		localparam int K = ROOT_W - 1 - j;
		logic [REM_W-1:0] trial;
		logic             take;

		assign trial = (REM_W'(root_s[j]) << (K + 1)) + (REM_W'(1) << (2 * K));
		assign take = rem_s[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (adv) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1]  <= take ? rem_s[j] - trial : rem_s[j];
				root_s[j+1] <= take ? (root_s[j] | (ROOT_W'(1) << K)) : root_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign root = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rem_s[ROOT_W] <= (REM_W'(root) << 1))
		else $error("square root remainder too large");
	a_root_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> root <= ROOT_W'(32'd1 << 28))
		else $error("square root above one");
	a_rem_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s[0]) |=> rem_s[1] <= $past(rem_s[0]))
		else $error("remainder grew");

endmodule

// File: hw/rtl/q2e_cordic.sv
`timescale 1ns / 1ps
module q2e_cordic import q2e_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_valid,
	input  logic signed [CXY_W-1:0] y,
	input  logic signed [CXY_W-1:0] x,
	output logic                    out_valid,
	output logic signed [ANG_W-1:0] angle
);

	logic                    v_s    [0:CORDIC_STAGES];
	logic                    zero_s [0:CORDIC_STAGES];
	logic signed [CXY_W-1:0] x_s    [0:CORDIC_STAGES];
	logic signed [CXY_W-1:0] y_s    [0:CORDIC_STAGES];
	logic signed [ANG_W-1:0] z_s    [0:CORDIC_STAGES];

	logic signed [CXY_W-1:0] px, py;
	logic signed [ANG_W-1:0] pz;

	// left half-plane: turn by 90 degrees first
	always_comb begin
		px = x;
		py = y;
		pz = '0;
		if (x < 0) begin
			if (y >= 0) begin
				px = y;
				py = -x;
				pz = HALF_PI_Q30;
			end else begin
				px = -y;
				py = x;
				pz = -HALF_PI_Q30;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]    <= px;
			y_s[0]    <= py;
			z_s[0]    <= pz;
			zero_s[0] <= (x == '0) && (y == '0);
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_angle(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_angle(5'(i));
				end
			end
		end
	end

	assign out_valid = v_s[CORDIC_STAGES];
	assign angle = zero_s[CORDIC_STAGES] ? '0 : z_s[CORDIC_STAGES];

	a_right_half: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> x_s[0] >= 0)
		else $error("vector not in right half-plane after pre-rotation");
	a_zero_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s[0] && zero_s[0]) |-> (z_s[0] == '0))
		else $error("zero vector got a pre-rotation");
	a_x_grows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[1] |-> x_s[1] >= $past(x_s[0]) || !$past(adv))
		else $error("vectoring shrank x");

endmodule

// File: hw/rtl/quaternion_to_euler_any_sequence_core.sv
`timescale 1ns / 1ps
// Quaternion (w,x,y,z, Q2.14) to three Euler angles (radians, Q3.13) for any of
// the twelve axis sequences chosen by the rotation_sequence register (reset zxy;
// codes 12-15 give all zeros). Fully pipelined: one item per cycle while the
// output is not stalled; the path runs through the term stages, the 29-stage
// bit-per-stage square root, the CORDIC stage chain and the output register. asin/acos
// arguments outside [-1,1] saturate and raise argument_clamped. When the output
// is stalled the pipeline keeps filling until its last stage holds an item.
module quaternion_to_euler_any_sequence_core import q2e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       quat_valid,
	output logic       quat_stall,
	input  quat_t      quat,
	output logic       euler_valid,
	input  logic       euler_stall,
	output euler_t     euler
);

	logic [3:0] seq_q;
	logic       adv, out_load, last_valid;

	logic               t_valid;
	side_t              t_side;
	logic [RAD_W-1:0]   t_rad;

	logic               q_valid;
	logic [ROOT_W-1:0]  q_root;
	side_t              q_side;

	logic signed [CXY_W-1:0] y0, x0, y1, x1, y2, x2, s_ext, r21_ext;
	logic                    c_valid [0:2];
	logic signed [ANG_W-1:0] ang [0:2];

	flag_t flag_s [0:CORDIC_LAT-1];

	logic   ev_q;
	euler_t euler_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_RESET;
		end else if (cfg_we) begin
			seq_q <= cfg_wdata;
		end
	end

	assign last_valid = c_valid[0];
	assign out_load = !ev_q || !euler_stall;
	assign adv = !last_valid || out_load;
	assign quat_stall = !adv;

	q2e_terms u_terms (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(quat_valid), .quat(quat), .seq(seq_q),
		.out_valid(t_valid), .side(t_side), .rad(t_rad)
	);

	q2e_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(t_valid), .rad(t_rad), .in_side(t_side),
		.out_valid(q_valid), .root(q_root), .out_side(q_side)
	);

	assign s_ext = CXY_W'(signed'({1'b0, q_root}));
	assign r21_ext = CXY_W'(q_side.r21);

	always_comb begin
		if (q_side.three) begin
			y0 = CXY_W'(q_side.r31); x0 = CXY_W'(q_side.r32);
			y1 = r21_ext;            x1 = s_ext;
			y2 = CXY_W'(q_side.r11); x2 = CXY_W'(q_side.r12);
		end else begin
			y0 = CXY_W'(q_side.r11); x0 = CXY_W'(q_side.r12);
			y1 = s_ext;              x1 = r21_ext;
			y2 = CXY_W'(q_side.r31); x2 = CXY_W'(q_side.r32);
		end
	end

	q2e_cordic u_cordic0 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(q_valid),
		.y(y0), .x(x0), .out_valid(c_valid[0]), .angle(ang[0])
	);
	q2e_cordic u_cordic1 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(q_valid),
		.y(y1), .x(x1), .out_valid(c_valid[1]), .angle(ang[1])
	);
	q2e_cordic u_cordic2 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(q_valid),
		.y(y2), .x(x2), .out_valid(c_valid[2]), .angle(ang[2])
	);

	// flags ride alongside the CORDIC chain
	always_ff @(posedge clk) begin
		if (adv) begin
			flag_s[0] <= q_side.flags;
			for (int i = 1; i < CORDIC_LAT; i++) begin
				flag_s[i] <= flag_s[i-1];
			end
		end
	end

	function automatic logic signed [15:0] to_q13(input logic signed [ANG_W-1:0] a);
		logic signed [ANG_W-1:0] r;
		r = a + ANG_W'(65536);
		return r[32:17];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= 1'b0;
		end else if (out_load) begin
			ev_q <= last_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && last_valid) begin
			if (flag_s[CORDIC_LAT-1].bad) begin
				euler_q <= '0;
			end else begin
				euler_q.angle_first      <= to_q13(ang[0]);
				euler_q.angle_second     <= to_q13(ang[1]);
				euler_q.angle_third      <= to_q13(ang[2]);
				euler_q.argument_clamped <= flag_s[CORDIC_LAT-1].clamped;
			end
		end
	end

	assign euler_valid = ev_q;
	assign euler = euler_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		quat_stall |-> (last_valid && ev_q && euler_stall))
		else $error("input stalled without a blocked output");
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(c_valid[0] == c_valid[1]) && (c_valid[1] == c_valid[2]))
		else $error("CORDIC lanes out of step");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_q && euler_stall) |=> ev_q)
		else $error("stalled item dropped");

endmodule
